>>> rtl/spd_pkg.sv
// shared command, status and code types for the sorted pair distance block
`timescale 1ns / 1ps

package spd_pkg;

	// index register operations
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_SET0,
		IDX_SET1,
		IDX_INC,
		IDX_DEC,
		IDX_FROM_I
	} idx_op_t;

	// read address sources
	typedef enum logic [2:0] {
		RA_I,
		RA_JM1,
		RA_JM2,
		RA_J,
		RA_JP1
	} rd_addr_t;

	// sort write data sources
	typedef enum logic {
		WS_SHIFT,
		WS_KEY
	} wr_src_t;

	// controller to datapath commands
	typedef struct packed {
		logic     wr_load;
		logic     wr_sort;
		wr_src_t  wr_src;
		logic     sort_list;
		idx_op_t  i_op;
		idx_op_t  j_op;
		logic     left_re;
		rd_addr_t left_addr;
		logic     right_re;
		rd_addr_t right_addr;
		logic     key_ld;
		logic     acc_clr;
		logic     dist_acc;
		logic     mcnt_clr;
		logic     mcnt_inc;
		logic     mul_ld;
		logic     sim_acc;
		logic     prev_clr;
		logic     out_ld;
		logic     set_clr;
	} spd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic i_ge_n;
		logic j_ge_n;
		logic j_is1;
		logic sort_gt;
		logic r_lt;
		logic r_eq;
		logic match_prev;
		logic out_free;
	} spd_status_t;

endpackage

>>> rtl/sorted_pair_distance_similarity.sv
// top level: sorted pair distance and similarity engine
//
//   channel   valid      stall      payload
//   input     in_valid   in_stall   left_value, right_value, last_pair
//   output    out_valid  out_stall  distance_sum, similarity_sum, pairs_used,
//                                   capacity_exceeded
//
// input beats load one pair per cycle into the two list memories while in_stall is low.
// after the last beat both lists are insertion sorted one after the other
// through the single ram read port, then a distance pass and a similarity pass
// run over the sorted lists.
// the input stalls from the last beat until the result enters the output register.
// reset clears the control state and fill count; memory contents need no clearing.
`timescale 1ns / 1ps

module sorted_pair_distance_similarity
	import spd_pkg::*;
#(
	parameter int MAX_PAIRS  = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] left_value,
	input  logic signed [31:0] right_value,
	input  logic               last_pair,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [47:0]        distance_sum,
	output logic signed [53:0] similarity_sum,
	output logic [10:0]        pairs_used,
	output logic               capacity_exceeded
);

	spd_cmd_t    cmd;
	spd_status_t st;

	// sequencer
	spd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_pair (last_pair),
		.in_stall  (in_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// memories and arithmetic
	spd_datapath #(
		.MAX_PAIRS  (MAX_PAIRS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.left_value        (left_value),
		.right_value       (right_value),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.distance_sum      (distance_sum),
		.similarity_sum    (similarity_sum),
		.pairs_used        (pairs_used),
		.capacity_exceeded (capacity_exceeded)
	);

endmodule

>>> rtl/spd_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module spd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/spd_datapath.sv
// datapath: list memories, indexes, sort key, sums and result register
`timescale 1ns / 1ps

module spd_datapath
	import spd_pkg::*;
#(
	parameter int MAX_PAIRS  = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spd_cmd_t           cmd,
	output spd_status_t        st,
	input  logic signed [31:0] left_value,
	input  logic signed [31:0] right_value,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [47:0]        distance_sum,
	output logic signed [53:0] similarity_sum,
	output logic [10:0]        pairs_used,
	output logic               capacity_exceeded
);

	localparam int AW = $clog2(MAX_PAIRS);
	localparam int CW = $clog2(MAX_PAIRS + 1);
	localparam int VB = VALUE_BITS;

	logic [CW-1:0] count_q, i_q, j_q, mcnt_q;
	logic          drop_q;
	logic          full;
	logic signed [VB-1:0] key_q, prev_v_q;
	logic          prev_valid_q;
	logic signed [VB+CW:0] prod_q;
	logic [47:0]   dist_q;
	logic [53:0]   sim_q;
	logic          out_valid_q;

	logic [VB-1:0] l_rdata, r_rdata, sel_rdata;
	logic [AW-1:0] l_raddr, r_raddr, waddr;
	logic [VB-1:0] l_wdata, r_wdata, sort_wdata;
	logic          l_we, r_we;

	logic signed [VB:0] diff;
	logic [VB:0]        abs_diff;
	logic signed [63:0] prod_ext;

	assign full = (count_q == CW'(MAX_PAIRS));

	// read address select
	function automatic logic [AW-1:0] addr_of(input rd_addr_t sel, input logic [CW-1:0] i,
			input logic [CW-1:0] j);
		logic [CW-1:0] a;
		unique case (sel)
			RA_I:    a = i;
			RA_JM1:  a = j - CW'(1);
			RA_JM2:  a = j - CW'(2);
			RA_J:    a = j;
			RA_JP1:  a = j + CW'(1);
			default: a = i;
		endcase
		return a[AW-1:0];
	endfunction

	assign l_raddr = addr_of(cmd.left_addr, i_q, j_q);
	assign r_raddr = addr_of(cmd.right_addr, i_q, j_q);

	// write port: load beats at the fill count, sort writes at j
	assign sort_wdata = (cmd.wr_src == WS_KEY) ? key_q : sel_rdata;
	assign waddr      = cmd.wr_load ? count_q[AW-1:0] : j_q[AW-1:0];
	assign l_we       = (cmd.wr_load && !full) || (cmd.wr_sort && !cmd.sort_list);
	assign r_we       = (cmd.wr_load && !full) || (cmd.wr_sort && cmd.sort_list);
	assign l_wdata    = cmd.wr_load ? left_value[VB-1:0] : sort_wdata;
	assign r_wdata    = cmd.wr_load ? right_value[VB-1:0] : sort_wdata;

	spd_ram #(.WIDTH(VB), .DEPTH(MAX_PAIRS)) u_left_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (waddr),
		.wdata (l_wdata),
		.re    (cmd.left_re),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	spd_ram #(.WIDTH(VB), .DEPTH(MAX_PAIRS)) u_right_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (waddr),
		.wdata (r_wdata),
		.re    (cmd.right_re),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	assign sel_rdata = cmd.sort_list ? r_rdata : l_rdata;

	// fill count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.set_clr) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.wr_load) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// rank indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			unique case (cmd.i_op)
				IDX_SET0: i_q <= '0;
				IDX_SET1: i_q <= CW'(1);
				IDX_INC:  i_q <= i_q + CW'(1);
				default:  i_q <= i_q;
			endcase
			unique case (cmd.j_op)
				IDX_SET0:   j_q <= '0;
				IDX_FROM_I: j_q <= i_q;
				IDX_DEC:    j_q <= j_q - CW'(1);
				IDX_INC:    j_q <= j_q + CW'(1);
				default:    j_q <= j_q;
			endcase
		end
	end

	// sort key
	always_ff @(posedge clk) begin
		if (cmd.key_ld) begin
			key_q <= sel_rdata;
		end
	end

	// rank distance term
	assign diff     = $signed({l_rdata[VB-1], l_rdata}) - $signed({r_rdata[VB-1], r_rdata});
	assign abs_diff = diff[VB] ? (VB+1)'(-diff) : diff;

	// match count, product and previous left value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			mcnt_q       <= '0;
		end else begin
			if (cmd.prev_clr) begin
				prev_valid_q <= 1'b0;
			end else if (cmd.mul_ld) begin
				prev_valid_q <= 1'b1;
			end
			if (cmd.mcnt_clr) begin
				mcnt_q <= '0;
			end else if (cmd.mcnt_inc) begin
				mcnt_q <= mcnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_ld) begin
			prev_v_q <= l_rdata;
			prod_q   <= $signed(l_rdata) * $signed({1'b0, mcnt_q});
		end
	end

	assign prod_ext = 64'(prod_q);

	// sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			sim_q  <= '0;
		end else if (cmd.acc_clr) begin
			dist_q <= '0;
			sim_q  <= '0;
		end else begin
			if (cmd.dist_acc) begin
				dist_q <= dist_q + 48'(abs_diff);
			end
			if (cmd.sim_acc) begin
				sim_q <= sim_q + prod_ext[53:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			distance_sum      <= dist_q;
			similarity_sum    <= $signed(sim_q);
			pairs_used        <= 11'(count_q);
			capacity_exceeded <= drop_q;
		end
	end

	assign out_valid = out_valid_q;

	// status to controller
	assign st.i_ge_n     = (i_q >= count_q);
	assign st.j_ge_n     = (j_q >= count_q);
	assign st.j_is1      = (j_q == CW'(1));
	assign st.sort_gt    = ($signed(sel_rdata) > key_q);
	assign st.r_lt       = ($signed(r_rdata) < $signed(l_rdata));
	assign st.r_eq       = (r_rdata == l_rdata);
	assign st.match_prev = prev_valid_q && ($signed(l_rdata) == prev_v_q);
	assign st.out_free   = !out_valid_q || !out_stall;

endmodule

>>> rtl/spd_ctrl.sv
// controller: load, insertion sort of both lists, distance pass, similarity pass
`timescale 1ns / 1ps

module spd_ctrl
	import spd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        last_pair,
	output logic        in_stall,
	input  spd_status_t st,
	output spd_cmd_t    cmd
);

	typedef enum logic [13:0] {
		S_LOAD       = 14'b00000000000001,
		S_SORT_START = 14'b00000000000010,
		S_SORT_KEY   = 14'b00000000000100,
		S_SORT_LD    = 14'b00000000001000,
		S_SORT_CMP   = 14'b00000000010000,
		S_SORT_INS   = 14'b00000000100000,
		S_DIST_RD    = 14'b00000001000000,
		S_DIST_EV    = 14'b00000010000000,
		S_SIM_RD     = 14'b00000100000000,
		S_SIM_EV     = 14'b00001000000000,
		S_SIM_SCAN   = 14'b00010000000000,
		S_SIM_MUL    = 14'b00100000000000,
		S_SIM_ACC    = 14'b01000000000000,
		S_FINISH     = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   list_q, list_d;

	// state and list select registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			list_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			list_q  <= list_d;
		end
	end

	assign in_stall = (state_q != S_LOAD);

	// next state and commands
	always_comb begin
		state_d       = state_q;
		list_d        = list_q;
		cmd           = '0;
		cmd.wr_src    = WS_SHIFT;
		cmd.i_op      = IDX_HOLD;
		cmd.j_op      = IDX_HOLD;
		cmd.left_addr = RA_I;
		cmd.right_addr = RA_I;
		cmd.sort_list = list_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.wr_load = 1'b1;
					if (last_pair) begin
						cmd.acc_clr = 1'b1;
						list_d      = 1'b0;
						state_d     = S_SORT_START;
					end
				end
			end
			S_SORT_START: begin
				cmd.i_op = IDX_SET1;
				state_d  = S_SORT_KEY;
			end
			S_SORT_KEY: begin
				if (st.i_ge_n) begin
					if (!list_q) begin
						list_d  = 1'b1;
						state_d = S_SORT_START;
					end else begin
						cmd.i_op = IDX_SET0;
						state_d  = S_DIST_RD;
					end
				end else begin
					cmd.left_re  = !list_q;
					cmd.right_re = list_q;
					cmd.j_op     = IDX_FROM_I;
					state_d      = S_SORT_LD;
				end
			end
			S_SORT_LD: begin
				cmd.key_ld     = 1'b1;
				cmd.left_re    = !list_q;
				cmd.right_re   = list_q;
				cmd.left_addr  = RA_JM1;
				cmd.right_addr = RA_JM1;
				state_d        = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				if (st.sort_gt) begin
					cmd.wr_sort = 1'b1;
					cmd.wr_src  = WS_SHIFT;
					cmd.j_op    = IDX_DEC;
					if (st.j_is1) begin
						state_d = S_SORT_INS;
					end else begin
						cmd.left_re    = !list_q;
						cmd.right_re   = list_q;
						cmd.left_addr  = RA_JM2;
						cmd.right_addr = RA_JM2;
					end
				end else begin
					state_d = S_SORT_INS;
				end
			end
			S_SORT_INS: begin
				cmd.wr_sort = 1'b1;
				cmd.wr_src  = WS_KEY;
				cmd.i_op    = IDX_INC;
				state_d     = S_SORT_KEY;
			end
			S_DIST_RD: begin
				if (st.i_ge_n) begin
					cmd.i_op     = IDX_SET0;
					cmd.j_op     = IDX_SET0;
					cmd.prev_clr = 1'b1;
					state_d      = S_SIM_RD;
				end else begin
					cmd.left_re  = 1'b1;
					cmd.right_re = 1'b1;
					state_d      = S_DIST_EV;
				end
			end
			S_DIST_EV: begin
				cmd.dist_acc = 1'b1;
				cmd.i_op     = IDX_INC;
				state_d      = S_DIST_RD;
			end
			S_SIM_RD: begin
				if (st.i_ge_n) begin
					state_d = S_FINISH;
				end else begin
					cmd.left_re    = 1'b1;
					cmd.right_re   = 1'b1;
					cmd.right_addr = RA_J;
					state_d        = S_SIM_EV;
				end
			end
			S_SIM_EV: begin
				if (st.match_prev) begin
					state_d = S_SIM_MUL;
				end else begin
					cmd.mcnt_clr = 1'b1;
					state_d      = S_SIM_SCAN;
				end
			end
			S_SIM_SCAN: begin
				priority if (!st.j_ge_n && st.r_lt) begin
					cmd.j_op       = IDX_INC;
					cmd.right_re   = 1'b1;
					cmd.right_addr = RA_JP1;
				end else if (!st.j_ge_n && st.r_eq) begin
					cmd.mcnt_inc   = 1'b1;
					cmd.j_op       = IDX_INC;
					cmd.right_re   = 1'b1;
					cmd.right_addr = RA_JP1;
				end else begin
					state_d = S_SIM_MUL;
				end
			end
			S_SIM_MUL: begin
				cmd.mul_ld = 1'b1;
				state_d    = S_SIM_ACC;
			end
			S_SIM_ACC: begin
				cmd.sim_acc = 1'b1;
				cmd.i_op    = IDX_INC;
				state_d     = S_SIM_RD;
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.out_ld  = 1'b1;
					cmd.set_clr = 1'b1;
					state_d     = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

>>> tb/tb.sv
// self-checking testbench for the sorted pair distance and similarity block
`timescale 1ns / 1ps

module tb;
	import spd_pkg::*;

	localparam int CAPACITY    = 1024;
	localparam int WATCH_LIMIT = 3000000;
	localparam int RAND_ITEMS  = 820;

	typedef struct {
		logic [47:0]        dtotal;
		logic signed [53:0] sim;
		logic [10:0]        used;
		logic               cap;
	} score_t;

	typedef struct {
		int     lval;
		int     rval;
		bit     fin;
		bit     typed;
		score_t want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] left_value;
	logic signed [31:0] right_value;
	logic               last_pair;
	logic               out_valid;
	logic               out_stall;
	logic [47:0]        distance_sum;
	logic signed [53:0] similarity_sum;
	logic [10:0]        pairs_used;
	logic               capacity_exceeded;

	score_t score_q[$];
	int     left_list[$];
	int     right_list[$];
	bit     overflow_seen;
	bit     calm;
	int     fail_count;
	int     idle_cycles;
	int     stall_left;
	row_t   rows[$];

	sorted_pair_distance_similarity i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_value(left_value), .right_value(right_value), .last_pair(last_pair),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance_sum(distance_sum), .similarity_sum(similarity_sum),
		.pairs_used(pairs_used), .capacity_exceeded(capacity_exceeded)
	);

	// clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ascending insertion sort of one list copy
	function automatic void sort_up(ref int a[$]);
		int key;
		int j;
		for (int i = 1; i < a.size(); i++) begin
			key = a[i];
			j = i;
			while (j > 0 && a[j-1] > key) begin
				a[j] = a[j-1];
				j--;
			end
			a[j] = key;
		end
	endfunction

	// score of the current data set
	function automatic score_t score_set();
		int     ls[$];
		int     rs[$];
		longint dsum;
		longint ssum;
		longint d;
		score_t s;
		ls = left_list;
		rs = right_list;
		sort_up(ls);
		sort_up(rs);
		dsum = 0;
		ssum = 0;
		for (int i = 0; i < ls.size(); i++) begin
			d = longint'(ls[i]) - longint'(rs[i]);
			dsum += (d < 0) ? -d : d;
			for (int k = 0; k < rs.size(); k++)
				if (rs[k] == ls[i])
					ssum += longint'(ls[i]);
		end
		s.dtotal = dsum[47:0];
		s.sim    = ssum[53:0];
		s.used   = 11'(ls.size());
		s.cap    = overflow_seen;
		return s;
	endfunction

	// track one accepted beat
	function automatic void absorb_pair(int l, int r, bit fin, bit typed, score_t want);
		if (left_list.size() < CAPACITY) begin
			left_list = {left_list, l};
			right_list = {right_list, r};
		end else begin
			overflow_seen = 1'b1;
		end
		if (fin) begin
			score_q = {score_q, (typed ? want : score_set())};
			left_list.delete();
			right_list.delete();
			overflow_seen = 1'b0;
		end
	endfunction

	// drive one beat and wait for it to be taken
	task automatic send_pair(int l, int r, bit fin, bit typed, score_t want);
		in_valid    <= 1'b1;
		left_value  <= l;
		right_value <= r;
		last_pair   <= fin;
		do @(posedge clk); while (in_stall);
		absorb_pair(l, r, fin, typed, want);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	function automatic row_t mk(int l, int r, bit fin, bit typed,
			longint d = 0, longint s = 0, int u = 0, bit c = 0);
		row_t x;
		x.lval = l;
		x.rval = r;
		x.fin = fin;
		x.typed = typed;
		x.want.dtotal = d[47:0];
		x.want.sim = s[53:0];
		x.want.used = 11'(u);
		x.want.cap = c;
		return x;
	endfunction

	// append one stimulus row
	function automatic void add_row(row_t x);
		rows = {rows, x};
	endfunction

	function automatic int rand_value(bit narrow);
		return narrow ? (int'($urandom_range(0, 8)) - 4) : int'($urandom);
	endfunction

	// stimulus
	initial begin
		score_t none;
		int n;
		bit narrow;
		none = '{default: '0};
		in_valid = 1'b0;
		left_value = '0;
		right_value = '0;
		last_pair = 1'b0;
		calm = 1'b0;
		overflow_seen = 1'b0;
		fail_count = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes and single-pair sets
		add_row(mk(32'h7fffffff, 32'h80000000, 1, 1, 64'hffffffff, 0, 1, 0));
		add_row(mk(32'h80000000, 32'h80000000, 1, 1, 0, -64'sd2147483648, 1, 0));
		add_row(mk(32'h7fffffff, 32'h7fffffff, 1, 1, 0, 64'sd2147483647, 1, 0));
		add_row(mk(-1, -1, 1, 1, 0, -1, 1, 0));
		add_row(mk(0, 0, 1, 1, 0, 0, 1, 0));
		// duplicates counted against each right match
		add_row(mk(3, 3, 0, 0));
		add_row(mk(3, 3, 1, 1, 0, 12, 2, 0));
		// unsorted set, read off the predictor
		add_row(mk(3, 4, 0, 0));
		add_row(mk(4, 3, 0, 0));
		add_row(mk(2, 5, 0, 0));
		add_row(mk(1, 3, 0, 0));
		add_row(mk(3, 9, 0, 0));
		add_row(mk(3, 3, 1, 0));
		add_row(mk(32'h80000000, 32'h7fffffff, 0, 0));
		add_row(mk(32'h7fffffff, 32'h80000000, 1, 0));
		foreach (rows[i])
			send_pair(rows[i].lval, rows[i].rval, rows[i].fin, rows[i].typed, rows[i].want);

		// full stores: ascending data keeps the sort short, beats beyond the capacity are dropped
		for (int k = 0; k < CAPACITY + 6; k++)
			send_pair(k * 3 - 1500, k * 2, k == CAPACITY + 5, 0, none);

		// hold off until the pipe drains
		in_valid <= 1'b0;
		while (score_q.size() != 0) @(posedge clk);

		// random small sets
		n = 0;
		while (n < RAND_ITEMS) begin
			int sz;
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12);
			narrow = $urandom_range(0, 1);
			calm = (n > RAND_ITEMS - 150);
			for (int k = 0; k < sz; k++)
				send_pair(rand_value(narrow), rand_value(narrow), k == sz - 1, 0, none);
			n += sz;
		end
		in_valid <= 1'b0;

		while (score_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// output stall in random bursts of random length, none near the end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (calm) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= int'($urandom_range(1, 15));
		end
	end

	// result checker
	always @(posedge clk) begin
		score_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (score_q.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = score_q.pop_front();
				if (distance_sum !== e.dtotal) begin
					$error("distance_sum exp %0d got %0d", e.dtotal, distance_sum);
					fail_count++;
				end
				if (similarity_sum !== e.sim) begin
					$error("similarity_sum exp %0d got %0d", e.sim, similarity_sum);
					fail_count++;
				end
				if (pairs_used !== e.used) begin
					$error("pairs_used exp %0d got %0d", e.used, pairs_used);
					fail_count++;
				end
				if (capacity_exceeded !== e.cap) begin
					$error("capacity_exceeded exp %0d got %0d", e.cap, capacity_exceeded);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

>>> sorted_pair_distance_similarity.f
rtl/spd_pkg.sv
rtl/spd_ram.sv
rtl/spd_datapath.sv
rtl/spd_ctrl.sv
rtl/sorted_pair_distance_similarity.sv
tb/tb.sv
